// ----- src/assert_macros.svh -----
// Assertion macros for the record sorter.
// Needs nothing else; the top level takes it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define TKS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define TKS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `TKS_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ----- src/tksort_pkg.sv -----
// Shared types and fixed field widths of the record sorter.
// No dependencies; every module of the sorter imports it.
package tksort_pkg;

   localparam int PRICE_W   = 34;
   localparam int TAG_W     = 16;
   localparam int WORD_W    = 64;
   localparam int BYTE_W    = 8;
   localparam int MAX_WORDS = 7;

   // Per-cycle command broadcast from the controller to every cell
   typedef struct packed {
      logic insert;
      logic drain;
   } tksort_ctl_type;

endpackage

// ----- src/two_key_record_sorter_unit.sv -----
// Record sorter top level; depends on tksort_pkg, tksort_title_norm and tksort_cell.
// Loading: one word accepted per cycle while busy is low; each is held in the staging
// register and placed in the chain in the next cycle. After the last_in word is staged,
// the drain state registers one result per cycle per stored record (one for an empty set);
// busy is high from then until the last result is registered. Results are never stalled.
// Synchronous reset clears count, flag and control; cells are undefined until loaded.
module two_key_record_sorter_unit import tksort_pkg::*; #(
   parameter int DEPTH       = 32,
   parameter int TITLE_WORDS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PRICE_W-1:0] req_price_cents,
   input  logic [WORD_W-1:0]  req_title_w0,
   input  logic [WORD_W-1:0]  req_title_w1,
   input  logic [WORD_W-1:0]  req_title_w2,
   input  logic [WORD_W-1:0]  req_title_w3,
   input  logic [WORD_W-1:0]  req_title_w4,
   input  logic [WORD_W-1:0]  req_title_w5,
   input  logic [WORD_W-1:0]  req_title_w6,
   input  logic [TAG_W-1:0]   req_record_tag,
   input  logic               req_in_use,
   input  logic               req_last_in,
   output logic               rsp_strobe,
   output logic [TAG_W-1:0]   rsp_out_tag,
   output logic [PRICE_W-1:0] rsp_out_price,
   output logic               rsp_empty_set,
   output logic               rsp_overflowed,
   output logic               rsp_last_out
);

`include "assert_macros.svh"

   localparam int TITLE_W = TITLE_WORDS * WORD_W;
   localparam int KEY_W   = PRICE_W + TITLE_W;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                 accept;
   logic [WORD_W-1:0]    words [MAX_WORDS];
   logic [TITLE_W-1:0]   title_raw, title_norm;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 overflow_ff, overflow_in;

   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_last_ff, stage_last_in;
   logic                 stage_use_ff, stage_use_in;
   logic [KEY_W-1:0]     stage_key_ff, stage_key_in;
   logic [TAG_W-1:0]     stage_tag_ff, stage_tag_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [PRICE_W-1:0]   rsp_price_ff, rsp_price_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_last_ff, rsp_last_in;

   tksort_ctl_type       ctl;
   logic [KEY_W-1:0]     cell_key [DEPTH];
   logic [TAG_W-1:0]     cell_tag [DEPTH];
   logic                 cell_gt  [DEPTH];
   logic                 cell_occ [DEPTH];

   // Take a word while loading and nothing final is pending
   assign busy   = (state_ff == ST_DRAIN) || (stage_valid_ff && stage_last_ff);
   assign accept = start && !busy;

   // Pack the title, word 0 on top
   assign words[0] = req_title_w0;
   assign words[1] = req_title_w1;
   assign words[2] = req_title_w2;
   assign words[3] = req_title_w3;
   assign words[4] = req_title_w4;
   assign words[5] = req_title_w5;
   assign words[6] = req_title_w6;

   for (genvar w = 0; w < TITLE_WORDS; w++) begin : g_pack
      assign title_raw[TITLE_W-1 - WORD_W*w -: WORD_W] = words[w];
   end

   tksort_title_norm #(
      .TITLE_WORDS (TITLE_WORDS)
   ) u_norm (
      .title_i (title_raw),
      .title_o (title_norm)
   );

   // Hold the accepted word in the staging register
   always_comb begin
      stage_valid_in = accept;
      stage_last_in  = stage_last_ff;
      stage_use_in   = stage_use_ff;
      stage_key_in   = stage_key_ff;
      stage_tag_in   = stage_tag_ff;
      if (accept) begin
         stage_last_in = req_last_in;
         stage_use_in  = req_in_use;
         stage_key_in  = {req_price_cents, title_norm};
         stage_tag_in  = req_record_tag;
      end
   end

   // Insert, count, and drain one record per cycle
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      ctl.insert    = 1'b0;
      ctl.drain     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_tag_in    = rsp_tag_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_LOAD: begin
            if (stage_valid_ff) begin
               if (stage_use_ff) begin
                  if (count_ff < CNT_W'(DEPTH)) begin
                     ctl.insert = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (stage_last_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_strobe_in = 1'b1;
            rsp_ovf_in    = overflow_ff;
            if (count_ff == '0) begin
               rsp_tag_in   = '0;
               rsp_price_in = '0;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_LOAD;
               overflow_in  = 1'b0;
            end else begin
               ctl.drain    = 1'b1;
               rsp_tag_in   = cell_tag[0];
               rsp_price_in = cell_key[0][KEY_W-1 -: PRICE_W];
               rsp_empty_in = 1'b0;
               rsp_last_in  = (count_ff == CNT_W'(1));
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in    = ST_LOAD;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         stage_valid_ff <= stage_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      stage_last_ff <= stage_last_in;
      stage_use_ff  <= stage_use_in;
      stage_key_ff  <= stage_key_in;
      stage_tag_ff  <= stage_tag_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Cell chain, kept sorted; cell 0 holds the smallest key
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         tksort_cell #(.KEY_W (KEY_W)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (stage_key_ff),
            .new_tag   (stage_tag_ff),
            .left_key  (stage_key_ff),
            .left_tag  (stage_tag_ff),
            .left_gt   (1'b0),
            .right_key (cell_key[i+1]),
            .right_tag (cell_tag[i+1]),
            .key_o     (cell_key[i]),
            .tag_o     (cell_tag[i]),
            .gt_o      (cell_gt[i])
         );
      end else if (i == DEPTH-1) begin : g_tail
         tksort_cell #(.KEY_W (KEY_W)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (stage_key_ff),
            .new_tag   (stage_tag_ff),
            .left_key  (cell_key[i-1]),
            .left_tag  (cell_tag[i-1]),
            .left_gt   (cell_gt[i-1]),
            .right_key (cell_key[i]),
            .right_tag (cell_tag[i]),
            .key_o     (cell_key[i]),
            .tag_o     (cell_tag[i]),
            .gt_o      (cell_gt[i])
         );
      end else begin : g_mid
         tksort_cell #(.KEY_W (KEY_W)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (stage_key_ff),
            .new_tag   (stage_tag_ff),
            .left_key  (cell_key[i-1]),
            .left_tag  (cell_tag[i-1]),
            .left_gt   (cell_gt[i-1]),
            .right_key (cell_key[i+1]),
            .right_tag (cell_tag[i+1]),
            .key_o     (cell_key[i]),
            .tag_o     (cell_tag[i]),
            .gt_o      (cell_gt[i])
         );
      end
   end

   // Drive the result ports from registers
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_out_price  = rsp_price_ff;
   assign rsp_empty_set  = rsp_empty_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_last_out   = rsp_last_ff;

   // Checks
   `TKS_ASSERT(a_strobe_from_drain, clock, reset,
      rsp_strobe_ff |-> $past(state_ff == ST_DRAIN),
      "result word without a drain cycle")
   `TKS_ASSERT_NEVER(a_count_bound, clock, reset,
      count_ff > CNT_W'(DEPTH),
      "stored count beyond depth")
   `TKS_ASSERT(a_empty_is_last, clock, reset,
      rsp_strobe_ff && rsp_empty_ff |-> rsp_last_ff && rsp_price_ff == '0,
      "empty result must be last and carry zero price")
   `TKS_ASSERT(a_run_end_clears, clock, reset,
      rsp_strobe_ff && rsp_last_ff |-> count_ff == '0 && state_ff == ST_LOAD && !overflow_ff,
      "run end did not clear count, flag and state")

endmodule

// ----- src/tksort_title_norm.sv -----
// Title normalizer: zeroes every byte after the first zero byte.
// Depends on tksort_pkg. A plain unsigned compare of normalized titles
// then matches the byte-wise compare that stops at a terminator.
module tksort_title_norm import tksort_pkg::*; #(
   parameter int TITLE_WORDS = 7
) (
   input  logic [TITLE_WORDS*WORD_W-1:0] title_i,
   output logic [TITLE_WORDS*WORD_W-1:0] title_o
);

   localparam int NBYTES = TITLE_WORDS * WORD_W / BYTE_W;
   localparam int TOP    = TITLE_WORDS * WORD_W - 1;

   logic [NBYTES-1:0] zero_flags;
   logic [NBYTES-1:0] keep;

   // Flag zero bytes; byte 0 sits at the top of the vector
   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         zero_flags[k] = (title_i[TOP - BYTE_W*k -: BYTE_W] == '0);
      end
   end

   // Keep a byte only when no earlier byte was zero
   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         keep[k] = ~|(zero_flags & ((NBYTES'(1) << k) - NBYTES'(1)));
      end
   end

   // Drop bytes past the terminator
   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         title_o[TOP - BYTE_W*k -: BYTE_W] =
            keep[k] ? title_i[TOP - BYTE_W*k -: BYTE_W] : '0;
      end
   end

endmodule

// ----- src/tksort_cell.sv -----
// One cell of the insertion chain: holds one record (key and tag).
// Depends on tksort_pkg. Compares against the broadcast word, takes the
// new word or its left neighbor on insert, its right neighbor on drain.
module tksort_cell import tksort_pkg::*; #(
   parameter int KEY_W = PRICE_W + MAX_WORDS*WORD_W
) (
   input  logic                 clock,
   input  tksort_ctl_type       ctl,
   input  logic                 occupied,
   input  logic [KEY_W-1:0]     new_key,
   input  logic [TAG_W-1:0]     new_tag,
   input  logic [KEY_W-1:0]     left_key,
   input  logic [TAG_W-1:0]     left_tag,
   input  logic                 left_gt,
   input  logic [KEY_W-1:0]     right_key,
   input  logic [TAG_W-1:0]     right_tag,
   output logic [KEY_W-1:0]     key_o,
   output logic [TAG_W-1:0]     tag_o,
   output logic                 gt_o
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // Empty cells and strictly greater keys sit after the new word
   assign gt_o = !occupied || (key_ff > new_key);

   // Pick next contents: drain shifts left, insert opens a slot
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctl.drain) begin
         key_in = right_key;
         tag_in = right_tag;
      end else if (ctl.insert && gt_o) begin
         if (left_gt) begin
            key_in = left_key;
            tag_in = left_tag;
         end else begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key_o = key_ff;
   assign tag_o = tag_ff;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for two_key_record_sorter_unit: directed and random record sets,
// checked against a sorter model kept here in step with every accepted word.
// Depends on tksort_pkg and the sorter RTL only.
module tb import tksort_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SORT_DEPTH  = 32;
   localparam int NAME_WORDS  = 7;
   localparam int TITLE_BITS  = MAX_WORDS * WORD_W;
   localparam int NAME_BYTES  = NAME_WORDS * WORD_W / BYTE_W;
   localparam logic [PRICE_W-1:0] PRICE_MAX = 34'd9000000000;
   // longer than a full drain plus the longest sender gap, so this is ample
   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PRINT_CAP = 40;

   typedef logic [TITLE_BITS-1:0] title_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      title_type          title;
      logic [TAG_W-1:0]   tag;
      logic               in_use;
      logic               last_in;
   } record_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [PRICE_W-1:0] price;
      logic               empty_set;
      logic               overflowed;
      logic               last_out;
   } sorted_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [PRICE_W-1:0] req_price_cents = '0;
   logic [WORD_W-1:0]  req_title_w0 = '0;
   logic [WORD_W-1:0]  req_title_w1 = '0;
   logic [WORD_W-1:0]  req_title_w2 = '0;
   logic [WORD_W-1:0]  req_title_w3 = '0;
   logic [WORD_W-1:0]  req_title_w4 = '0;
   logic [WORD_W-1:0]  req_title_w5 = '0;
   logic [WORD_W-1:0]  req_title_w6 = '0;
   logic [TAG_W-1:0]   req_record_tag = '0;
   logic               req_in_use = 1'b0;
   logic               req_last_in = 1'b0;
   logic               rsp_strobe;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [PRICE_W-1:0] rsp_out_price;
   logic               rsp_empty_set;
   logic               rsp_overflowed;
   logic               rsp_last_out;

   // sorter model state
   logic [PRICE_W-1:0] held_price [SORT_DEPTH];
   title_type          held_title [SORT_DEPTH];
   logic [TAG_W-1:0]   held_tag   [SORT_DEPTH];
   int                 held_count = 0;
   bit                 held_overflow = 1'b0;
   sorted_word_type    sorted_q [$];

   int mismatches = 0;
   int idle_pct = 0;

   two_key_record_sorter_unit #(
      .DEPTH       (SORT_DEPTH),
      .TITLE_WORDS (NAME_WORDS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_price_cents (req_price_cents),
      .req_title_w0    (req_title_w0),
      .req_title_w1    (req_title_w1),
      .req_title_w2    (req_title_w2),
      .req_title_w3    (req_title_w3),
      .req_title_w4    (req_title_w4),
      .req_title_w5    (req_title_w5),
      .req_title_w6    (req_title_w6),
      .req_record_tag  (req_record_tag),
      .req_in_use      (req_in_use),
      .req_last_in     (req_last_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_price   (rsp_out_price),
      .rsp_empty_set   (rsp_empty_set),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_last_out    (rsp_last_out)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // True when held entry slot sorts after the incoming record.
   // Title bytes compare unsigned and stop at the first zero byte.
   function automatic bit goes_after(input int slot, input logic [PRICE_W-1:0] price,
                                     input title_type title);
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      if (held_price[slot] != price)
         return held_price[slot] > price;
      for (int k = 0; k < NAME_BYTES; k++) begin
         a = held_title[slot][TITLE_BITS-1-BYTE_W*k -: BYTE_W];
         b = title[TITLE_BITS-1-BYTE_W*k -: BYTE_W];
         if (a != b)
            return a > b;
         if (a == '0)
            return 1'b0;
      end
      return 1'b0;
   endfunction

   // Insert one accepted word into the model; on last_in, queue the sorted drain.
   task automatic sort_accepted(input record_type rec);
      int slot;
      sorted_word_type res;
      if (rec.in_use) begin
         if (held_count >= SORT_DEPTH) begin
            held_overflow = 1'b1;
         end else begin
            slot = held_count;
            while (slot > 0 && goes_after(slot - 1, rec.price, rec.title)) begin
               held_price[slot] = held_price[slot-1];
               held_title[slot] = held_title[slot-1];
               held_tag[slot]   = held_tag[slot-1];
               slot--;
            end
            held_price[slot] = rec.price;
            held_title[slot] = rec.title;
            held_tag[slot]   = rec.tag;
            held_count++;
         end
      end
      if (rec.last_in) begin
         if (held_count == 0) begin
            res = '{tag: '0, price: '0, empty_set: 1'b1, overflowed: held_overflow,
                    last_out: 1'b1};
            sorted_q.push_back(res);
         end else begin
            for (int i = 0; i < held_count; i++) begin
               res = '{tag: held_tag[i], price: held_price[i], empty_set: 1'b0,
                       overflowed: held_overflow, last_out: (i == held_count - 1)};
               sorted_q.push_back(res);
            end
         end
         held_count = 0;
         held_overflow = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Compare one result word with the oldest expected one.
   task automatic check_result();
      sorted_word_type want;
      if (sorted_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result tag %h price %0d",
                                   rsp_out_tag, rsp_out_price));
         return;
      end
      want = sorted_q.pop_front();
      if (rsp_out_tag !== want.tag)
         report_mismatch($sformatf("out_tag %h, want %h", rsp_out_tag, want.tag));
      if (rsp_out_price !== want.price)
         report_mismatch($sformatf("out_price %0d, want %0d", rsp_out_price, want.price));
      if (rsp_empty_set !== want.empty_set)
         report_mismatch($sformatf("empty_set %b, want %b", rsp_empty_set, want.empty_set));
      if (rsp_overflowed !== want.overflowed)
         report_mismatch($sformatf("overflowed %b, want %b", rsp_overflowed, want.overflowed));
      if (rsp_last_out !== want.last_out)
         report_mismatch($sformatf("last_out %b, want %b", rsp_last_out, want.last_out));
   endtask

   // Sample both channels on the rising edge, before the design updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sort_accepted('{price: req_price_cents,
                            title: {req_title_w0, req_title_w1, req_title_w2, req_title_w3,
                                    req_title_w4, req_title_w5, req_title_w6},
                            tag: req_record_tag, in_use: req_in_use, last_in: req_last_in});
         if (rsp_strobe)
            check_result();
      end
   end

   // End the run when nothing moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Drive one word and hold it until accepted; start stays high afterward.
   task automatic send_record(input record_type rec);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start           <= 1'b1;
      req_price_cents <= rec.price;
      req_title_w0    <= rec.title[TITLE_BITS-1 -: WORD_W];
      req_title_w1    <= rec.title[TITLE_BITS-1-WORD_W -: WORD_W];
      req_title_w2    <= rec.title[TITLE_BITS-1-2*WORD_W -: WORD_W];
      req_title_w3    <= rec.title[TITLE_BITS-1-3*WORD_W -: WORD_W];
      req_title_w4    <= rec.title[TITLE_BITS-1-4*WORD_W -: WORD_W];
      req_title_w5    <= rec.title[TITLE_BITS-1-5*WORD_W -: WORD_W];
      req_title_w6    <= rec.title[WORD_W-1:0];
      req_record_tag  <= rec.tag;
      req_in_use      <= rec.in_use;
      req_last_in     <= rec.last_in;
      do
         @(posedge clock);
      while (busy);
   endtask

   function automatic title_type text_title(input string s);
      title_type t;
      t = '0;
      for (int k = 0; k < s.len() && k < NAME_BYTES; k++)
         t[TITLE_BITS-1-BYTE_W*k -: BYTE_W] = s[k];
      return t;
   endfunction

   // Zero-padded text; a narrow alphabet makes shared prefixes and ties common.
   function automatic title_type random_text(input int len, input bit narrow);
      title_type t;
      t = '0;
      for (int k = 0; k < len; k++)
         t[TITLE_BITS-1-BYTE_W*k -: BYTE_W] = narrow ? BYTE_W'($urandom_range(97, 99))
                                                     : BYTE_W'($urandom_range(1, 255));
      return t;
   endfunction

   function automatic record_type random_record();
      record_type rec;
      logic [63:0] wide;
      int len;
      case ($urandom_range(0, 3))
         0: rec.price = ($urandom_range(0, 1) != 0) ? PRICE_MAX : PRICE_W'($urandom_range(0, 3));
         1: begin
            wide = {$urandom, $urandom} % (64'(PRICE_MAX) + 64'd1);
            rec.price = wide[PRICE_W-1:0];
         end
         2: rec.price = PRICE_W'($urandom_range(0, 2));
         default: rec.price = (PRICE_W'(1) << 33) + PRICE_W'($urandom_range(0, 999));
      endcase
      case ($urandom_range(0, 7))
         0: rec.title = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         1, 2: rec.title = random_text($urandom_range(0, 3), 1'b1);
         3: begin
            // text, terminator, then bytes that must not take part in the compare
            len = $urandom_range(0, NAME_BYTES - 2);
            rec.title = random_text(len, 1'b1);
            for (int k = len + 1; k < NAME_BYTES; k++)
               rec.title[TITLE_BITS-1-BYTE_W*k -: BYTE_W] = BYTE_W'($urandom);
         end
         default: rec.title = random_text($urandom_range(0, NAME_BYTES), $urandom_range(0, 1));
      endcase
      rec.tag = TAG_W'($urandom);
      rec.in_use = 1'b1;
      rec.last_in = 1'b0;
      return rec;
   endfunction

   function automatic record_type make_record(input logic [PRICE_W-1:0] price,
                                              input title_type title,
                                              input logic [TAG_W-1:0] tag, input logic in_use,
                                              input logic last_in);
      record_type rec;
      rec = '{price: price, title: title, tag: tag, in_use: in_use, last_in: last_in};
      return rec;
   endfunction

   // Empty set, then a single stored record.
   task automatic test_empty_set();
      send_record(make_record('0, '0, 16'h1234, 1'b0, 1'b1));
      send_record(make_record(PRICE_W'(42), text_title("solo"), 16'h00a5, 1'b1, 1'b1));
   endtask

   // Price extremes and tag extremes; an unused word closes the set.
   task automatic test_price_extremes();
      send_record(make_record(PRICE_MAX, text_title("top"), 16'hffff, 1'b1, 1'b0));
      send_record(make_record('0, text_title("floor"), 16'h0000, 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(1) << 33, text_title("mid"), 16'haaaa, 1'b1, 1'b0));
      send_record(make_record((PRICE_W'(1) << 33) - 1, text_title("mid"), 16'h5555, 1'b1, 1'b0));
      send_record(make_record(PRICE_MAX, '1, 16'h0001, 1'b0, 1'b1));
   endtask

   // Title ordering at equal price: prefixes, unsigned bytes, the last byte, and
   // bytes after the terminator that must be ignored.
   task automatic test_title_order();
      title_type t;
      send_record(make_record(PRICE_W'(500), text_title("b"), 16'd1, 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(500), text_title("a"), 16'd2, 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(500), text_title("ab"), 16'd3, 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(500), '0, 16'd4, 1'b1, 1'b0));
      t = '0;
      t[TITLE_BITS-1 -: BYTE_W] = 8'h80;
      send_record(make_record(PRICE_W'(500), t, 16'd5, 1'b1, 1'b0));
      t[TITLE_BITS-1 -: BYTE_W] = 8'h7f;
      send_record(make_record(PRICE_W'(500), t, 16'd6, 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(500), '1, 16'd7, 1'b1, 1'b0));
      t = '1;
      t[BYTE_W-1:0] = 8'hfe;
      send_record(make_record(PRICE_W'(500), t, 16'd8, 1'b1, 1'b0));
      t = text_title("a");
      t[TITLE_BITS-1-2*BYTE_W -: BYTE_W] = "X";
      send_record(make_record(PRICE_W'(500), t, 16'd9, 1'b1, 1'b0));
      send_record(make_record('0, '0, 16'd10, 1'b0, 1'b1));
   endtask

   // Identical keys keep load order, last word stored too.
   task automatic test_tie_order();
      for (int i = 0; i < 3; i++)
         send_record(make_record(PRICE_W'(777), text_title("same"), TAG_W'(16 + i), 1'b1, 1'b0));
      send_record(make_record(PRICE_W'(777), text_title("same"), 16'd19, 1'b1, 1'b1));
   endtask

   // Fill the store past its depth; the closing word is dropped as well.
   task automatic test_full_store();
      record_type rec;
      int extra;
      extra = $urandom_range(1, 4);
      for (int i = 0; i < SORT_DEPTH + extra; i++) begin
         rec = random_record();
         send_record(rec);
      end
      rec = random_record();
      rec.last_in = 1'b1;
      send_record(rec);
   endtask

   // Random sets, mostly small, a few past the depth, with ignored noise words.
   task automatic test_random_sets(input int idle, input int quota);
      record_type rec;
      int sent;
      int size;
      sent = 0;
      idle_pct = idle;
      while (sent < quota) begin
         size = ($urandom_range(0, 11) == 0) ? $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 6)
                                             : $urandom_range(0, 10);
         for (int n = 0; n < size; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               rec = random_record();
               rec.in_use = 1'b0;
               send_record(rec);
            end
            rec = random_record();
            rec.in_use = ($urandom_range(0, 15) != 0);
            send_record(rec);
            sent++;
         end
         rec = random_record();
         rec.in_use = ($urandom_range(0, 3) != 0);
         rec.last_in = 1'b1;
         send_record(rec);
         sent++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_set();
      test_price_extremes();
      test_title_order();
      test_tie_order();
      test_full_store();
      test_random_sets(0, 80);
      test_random_sets(47, 80);
      test_random_sets(11, 80);
      start <= 1'b0;
      @(posedge clock);
      while (sorted_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/tksort_pkg.sv
src/tksort_title_norm.sv
src/tksort_cell.sv
src/two_key_record_sorter_unit.sv
sim/tb.sv
